>>> sv/ccfs_pkg.sv
package ccfs_pkg;

    // Fixed-point format of positions and velocities
    localparam int FRAC_BITS = 16;

    // Field widths
    localparam int CHG_W  = 15;
    localparam int VAL_W  = 32;
    localparam int CFG_W  = 15;

    // Datapath widths
    localparam int DIFF_W = VAL_W + 2;               // position difference, signed
    localparam int MAG_W  = VAL_W + 1;               // |difference|
    localparam int QS_W   = CHG_W + 1;               // force charge, signed
    localparam int SQ_W   = 2 * MAG_W;               // dx^2 + dy^2
    localparam int ROOT_W = MAG_W;                   // floor(sqrt(S))
    localparam int SREM_W = ROOT_W + 3;              // root remainder
    localparam int R25_W  = ROOT_W + 5;              // 25 * R
    localparam int DEN_W  = SQ_W + R25_W;            // 25 * S * R
    localparam int PROD_W = CHG_W + MAG_W;           // |q| * |dn|
    localparam int NUM_W  = PROD_W + 3 * FRAC_BITS;  // dividend of a force term
    localparam int MIX_W  = 48;                      // |qi*vi + qj*vj|
    localparam int CELL_W = 18;                      // cell index with offset, signed
    localparam int STEP_W = 7;                       // iteration counter

    localparam logic [MAG_W-1:0] TERM_CAP = 33'h1_0000_0000;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_FRAME  = 2'd2,
        OP_MOUSE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_FIELD_WIDTH  = 2'd0,
        REG_FIELD_HEIGHT = 2'd1,
        REG_MOUSE_FORCE  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [CHG_W-1:0] charge;
        logic signed [VAL_W-1:0] pos_x;
        logic signed [VAL_W-1:0] pos_y;
        logic signed [VAL_W-1:0] vel_x;
        logic signed [VAL_W-1:0] vel_y;
    } entry_t;

    function automatic logic [CHG_W-1:0] charge_mag(input logic signed [CHG_W-1:0] q);
        charge_mag = q[CHG_W-1] ? CHG_W'(0 - q) : q;
    endfunction

    function automatic logic [MAG_W-1:0] diff_mag(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] m;
        m = d[DIFF_W-1] ? DIFF_W'(0 - d) : d;
        diff_mag = m[MAG_W-1:0];
    endfunction

    // floor(log10(s)), capped at 4
    function automatic logic [2:0] decade(input logic [CHG_W:0] s);
        if (s < 16'd10)         decade = 3'd0;
        else if (s < 16'd100)   decade = 3'd1;
        else if (s < 16'd1000)  decade = 3'd2;
        else if (s < 16'd10000) decade = 3'd3;
        else                    decade = 3'd4;
    endfunction

    // cell index, truncated toward zero
    function automatic logic signed [CELL_W-1:0] cell_of(input logic signed [VAL_W-1:0] p);
        logic [VAL_W:0] m;
        logic [VAL_W:0] c;
        m = p[VAL_W-1] ? (33'd0 - {p[VAL_W-1], p}) : {1'b0, p};
        c = m >> FRAC_BITS;
        cell_of = p[VAL_W-1] ? CELL_W'(18'd0 - c[CELL_W-1:0]) : c[CELL_W-1:0];
    endfunction

    function automatic logic signed [CELL_W-1:0] wrap_once(input logic signed [CELL_W-1:0] c,
                                                           input logic [7:0] size);
        logic signed [CELL_W-1:0] sz;
        sz = $signed({{(CELL_W-8){1'b0}}, size});
        if (c < 0)        wrap_once = c + sz;
        else if (c >= sz) wrap_once = c - sz;
        else              wrap_once = c;
    endfunction

    // p + v with one wrap over the field span, clamped to 32 bits
    function automatic logic signed [VAL_W-1:0] advance(input logic signed [VAL_W-1:0] p,
                                                        input logic signed [VAL_W-1:0] v,
                                                        input logic [7:0] size);
        logic signed [DIFF_W-1:0] span;
        logic signed [DIFF_W-1:0] s;
        logic signed [DIFF_W-1:0] w;
        span = $signed({{(DIFF_W-8-FRAC_BITS){1'b0}}, size, {FRAC_BITS{1'b0}}});
        s = DIFF_W'(p) + DIFF_W'(v);
        if (s < 0)          w = s + span;
        else if (s >= span) w = s - span;
        else                w = s;
        if (!w[DIFF_W-1] && (w[DIFF_W-2:VAL_W-1] != '0))
            advance = 32'sh7FFF_FFFF;
        else if (w[DIFF_W-1] && (w[DIFF_W-2:VAL_W-1] != '1))
            advance = 32'sh8000_0000;
        else
            advance = w[VAL_W-1:0];
    endfunction

endpackage

>>> sv/coulomb_charge_frame_step.sv
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------------------------
// config    | cfg_we                 | cfg_index, cfg_data
// input     | in_valid / in_stall    | op, charge, pos_x/y, vel_x/y, mouse_x/y, mouse_sign
// output    | out_valid / out_stall  | index, charge_out, pos/vel_x/y_out, saturated, last
//
// A frame runs the force path for each ordered pair that takes it and a velocity
// mix for each colliding pair, row by row, then a position pass over every entry,
// and emits every entry. A mouse op runs the force path once per charged entry and
// then emits every entry. The force path is built on the shared bit-serial
// multiplier, the radix-2 square root and the radix-2 divider.
// Reset loads the register defaults and empties the store; entry memory is
// not cleared. in_stall is high while the sequencer is busy; out_stall holds
// the output register and the sequencer waits before loading the next entry.
module coulomb_charge_frame_step
    import ccfs_pkg::*;
#(
    parameter int MAX_CHARGES = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              op,
    input  logic signed [CHG_W-1:0] charge,
    input  logic signed [VAL_W-1:0] pos_x,
    input  logic signed [VAL_W-1:0] pos_y,
    input  logic signed [VAL_W-1:0] vel_x,
    input  logic signed [VAL_W-1:0] vel_y,
    input  logic [7:0]              mouse_x,
    input  logic [7:0]              mouse_y,
    input  logic                    mouse_sign,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [5:0]              index,
    output logic signed [CHG_W-1:0] charge_out,
    output logic signed [VAL_W-1:0] pos_x_out,
    output logic signed [VAL_W-1:0] pos_y_out,
    output logic signed [VAL_W-1:0] vel_x_out,
    output logic signed [VAL_W-1:0] vel_y_out,
    output logic                    saturated,
    output logic                    last
);

    localparam int IDX_W = $clog2(MAX_CHARGES);
    localparam int CNT_W = $clog2(MAX_CHARGES + 1);

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_I,
        S_LD_I,
        S_RD_J,
        S_LD_J,
        S_PAIR,
        S_FSTART,
        S_MULX,
        S_MULY,
        S_SQRT,
        S_R25,
        S_MULD,
        S_DSET,
        S_DIV,
        S_DEND,
        S_MIXMUL,
        S_MIXSUM,
        S_WR_I,
        S_WR_J,
        S_NEXT_I,
        S_POS_RD,
        S_POS_LD,
        S_POS_WR,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    state_t state_reg;

    // configuration
    logic [7:0]              width_reg;
    logic [7:0]              height_reg;
    logic signed [CFG_W-1:0] mforce_reg;

    // sequencer
    logic [CNT_W-1:0]        count_reg;
    logic [IDX_W-1:0]        i_reg;
    logic [IDX_W-1:0]        j_reg;
    logic                    frame_reg;
    logic                    mix_reg;
    logic                    axis_reg;
    logic [STEP_W-1:0]       cnt_reg;
    logic [MAX_CHARGES-1:0]  sat_reg;

    // working copies of entries i and j
    entry_t                  ei_reg;
    entry_t                  ej_reg;

    // force operands
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [QS_W-1:0]   q_reg;
    logic signed [DIFF_W-1:0] mpx_reg;
    logic signed [DIFF_W-1:0] mpy_reg;

    // shared arithmetic
    logic [DEN_W-1:0]        acc_reg;
    logic [DEN_W-1:0]        mcand_reg;
    logic [R25_W-1:0]        mplier_reg;
    logic [SQ_W-1:0]         s_reg;
    logic [SQ_W-1:0]         rad_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [SREM_W-1:0]       srem_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [NUM_W-1:0]        nshift_reg;
    logic [NUM_W-1:0]        quo_reg;
    logic signed [MIX_W-1:0] pa_reg;
    logic signed [MIX_W-1:0] pb_reg;
    logic                    neg_reg;

    // output register
    logic                    out_valid_reg;
    logic [5:0]              index_reg;
    entry_t                  out_reg;
    logic                    sat_out_reg;
    logic                    last_reg;

    // entry memory
    entry_t                  entry_mem [MAX_CHARGES];
    entry_t                  rd_data_reg;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [IDX_W-1:0]        mem_raddr;
    entry_t                  mem_wdata;

    logic                    in_accept;
    logic                    i_last;
    logic                    j_last;
    logic                    step_last;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign i_last    = (CNT_W'(i_reg) + CNT_W'(1)) == count_reg;
    assign j_last    = (CNT_W'(j_reg) + CNT_W'(1)) == count_reg;
    assign step_last = (cnt_reg == STEP_W'(1));

    // ---------------------------------------------------------------------
    // Pair geometry: collision test on the wrapped grid
    // ---------------------------------------------------------------------
    logic [CHG_W-1:0]        qi_mag;
    logic [CHG_W-1:0]        qj_mag;
    logic [CHG_W:0]          q_sum;
    logic [2:0]              reach;
    logic signed [CELL_W-1:0] cix, ciy, cjx, cjy;
    logic                    hit_x, hit_y, collide;

    always_comb
    begin
        qi_mag = charge_mag(ei_reg.charge);
        qj_mag = charge_mag(ej_reg.charge);
        q_sum  = (CHG_W+1)'(qi_mag) + (CHG_W+1)'(qj_mag);
        reach  = decade(q_sum);
        cix    = cell_of(ei_reg.pos_x);
        ciy    = cell_of(ei_reg.pos_y);
        cjx    = cell_of(ej_reg.pos_x);
        cjy    = cell_of(ej_reg.pos_y);
        hit_x  = 1'b0;
        hit_y  = 1'b0;
        for (int l = -4; l <= 4; l++)
        begin
            if ((l >= -int'(reach)) && (l <= int'(reach)))
            begin
                if (wrap_once(cjx + CELL_W'(l), width_reg) == cix)
                    hit_x = 1'b1;
                if (wrap_once(cjy + CELL_W'(l), height_reg) == ciy)
                    hit_y = 1'b1;
            end
        end
        collide = hit_x && hit_y && (i_reg != j_reg);
    end

    // ---------------------------------------------------------------------
    // Shared arithmetic steps
    // ---------------------------------------------------------------------
    logic [MAG_W-1:0]        ax, ay, an_cur;
    logic [CHG_W-1:0]        qm;
    logic [DEN_W-1:0]        acc_next;
    logic [SREM_W-1:0]       srem_shift;
    logic [SREM_W-1:0]       srem_trial;
    logic                    root_bit;
    logic [R25_W-1:0]        r25;
    logic [DEN_W:0]          rem_shift;
    logic                    quo_bit;
    logic [DEN_W-1:0]        rem_next;
    logic [PROD_W-1:0]       prod_q;

    always_comb
    begin
        ax     = diff_mag(dx_reg);
        ay     = diff_mag(dy_reg);
        an_cur = axis_reg ? ay : ax;
        qm     = q_reg[QS_W-1] ? CHG_W'(QS_W'(0) - q_reg) : q_reg[CHG_W-1:0];
        prod_q = PROD_W'(qm) * PROD_W'(an_cur);

        // shift-add multiply, one multiplier bit a cycle
        acc_next = acc_reg + (mplier_reg[0] ? mcand_reg : '0);

        // restoring square root, two radicand bits a cycle
        srem_shift = {srem_reg[SREM_W-3:0], rad_reg[SQ_W-1 -: 2]};
        srem_trial = SREM_W'({root_reg, 2'b01});
        root_bit   = (srem_shift >= srem_trial);
        r25        = (R25_W'(root_reg) << 4) + (R25_W'(root_reg) << 3) + R25_W'(root_reg);

        // restoring divide, one quotient bit a cycle
        rem_shift = {rem_reg, nshift_reg[NUM_W-1]};
        quo_bit   = (rem_shift >= {1'b0, den_reg});
        rem_next  = quo_bit ? DEN_W'(rem_shift - {1'b0, den_reg}) : rem_shift[DEN_W-1:0];
    end

    // force term on the current axis and its saturating velocity update
    logic [MAG_W-1:0]        term_mag;
    logic signed [VAL_W+2:0] term;
    logic signed [VAL_W-1:0] v_cur;
    logic signed [VAL_W+2:0] v_sum;
    logic                    v_over, v_under;
    logic signed [VAL_W-1:0] v_force;
    logic signed [VAL_W-1:0] v_mix;
    logic signed [MIX_W:0]   mix_sum;
    logic [MIX_W-1:0]        mix_mag;

    always_comb
    begin
        if ((q_reg == '0) || (an_cur == '0))
            term_mag = '0;
        else if (quo_reg > NUM_W'(TERM_CAP))
            term_mag = TERM_CAP;
        else
            term_mag = quo_reg[MAG_W-1:0];
        if (q_reg[QS_W-1] ^ (axis_reg ? dy_reg[DIFF_W-1] : dx_reg[DIFF_W-1]))
            term = (VAL_W+3)'(0) - (VAL_W+3)'(term_mag);
        else
            term = (VAL_W+3)'(term_mag);
        v_cur   = axis_reg ? ei_reg.vel_y : ei_reg.vel_x;
        v_sum   = (VAL_W+3)'(v_cur) + term;
        v_over  = !v_sum[VAL_W+2] && (v_sum[VAL_W+1:VAL_W-1] != '0);
        v_under = v_sum[VAL_W+2] && (v_sum[VAL_W+1:VAL_W-1] != '1);
        if (v_over)
            v_force = 32'sh7FFF_FFFF;
        else if (v_under)
            v_force = 32'sh8000_0000;
        else
            v_force = v_sum[VAL_W-1:0];

        v_mix   = neg_reg ? VAL_W'(0 - quo_reg[VAL_W-1:0]) : quo_reg[VAL_W-1:0];
        mix_sum = (MIX_W+1)'(pa_reg) + (MIX_W+1)'(pb_reg);
        mix_mag = mix_sum[MIX_W] ? MIX_W'(0 - mix_sum) : mix_sum[MIX_W-1:0];
    end

    // ---------------------------------------------------------------------
    // Entry memory ports
    // ---------------------------------------------------------------------
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = i_reg;
        mem_wdata = ei_reg;
        mem_raddr = i_reg;
        case (state_reg)
            S_IDLE:
            begin
                mem_waddr        = count_reg[IDX_W-1:0];
                mem_wdata.charge = charge;
                mem_wdata.pos_x  = pos_x;
                mem_wdata.pos_y  = pos_y;
                mem_wdata.vel_x  = vel_x;
                mem_wdata.vel_y  = vel_y;
                mem_we = in_accept && (op_t'(op) == OP_APPEND) &&
                         (count_reg < CNT_W'(MAX_CHARGES));
            end
            S_RD_J:
                mem_raddr = j_reg;
            S_WR_I:
                mem_we = 1'b1;
            S_WR_J:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = ej_reg;
            end
            S_POS_WR:
            begin
                mem_we          = 1'b1;
                mem_wdata.pos_x = advance(ei_reg.pos_x, ei_reg.vel_x, width_reg);
                mem_wdata.pos_y = advance(ei_reg.pos_y, ei_reg.vel_y, height_reg);
            end
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= entry_mem[mem_raddr];
    end

    // ---------------------------------------------------------------------
    // Sequencer and datapath registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= 8'd160;
            height_reg    <= 8'd80;
            mforce_reg    <= 15'sd100;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            frame_reg     <= 1'b0;
            mix_reg       <= 1'b0;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            sat_reg       <= '0;
            ei_reg        <= '0;
            ej_reg        <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            q_reg         <= '0;
            mpx_reg       <= '0;
            mpy_reg       <= '0;
            acc_reg       <= '0;
            mcand_reg     <= '0;
            mplier_reg    <= '0;
            s_reg         <= '0;
            rad_reg       <= '0;
            root_reg      <= '0;
            srem_reg      <= '0;
            den_reg       <= '0;
            rem_reg       <= '0;
            nshift_reg    <= '0;
            quo_reg       <= '0;
            pa_reg        <= '0;
            pb_reg        <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            index_reg     <= '0;
            out_reg       <= '0;
            sat_out_reg   <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_FIELD_WIDTH:  width_reg  <= cfg_data[7:0];
                    REG_FIELD_HEIGHT: height_reg <= cfg_data[7:0];
                    REG_MOUSE_FORCE:  mforce_reg <= cfg_data;
                    default:          ;
                endcase
            end

            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        case (op_t'(op))
                            OP_CLEAR:
                                count_reg <= '0;
                            OP_APPEND:
                                if (count_reg < CNT_W'(MAX_CHARGES))
                                    count_reg <= count_reg + CNT_W'(1);
                            OP_FRAME:
                                if (count_reg != '0)
                                begin
                                    frame_reg <= 1'b1;
                                    i_reg     <= '0;
                                    sat_reg   <= '0;
                                    state_reg <= S_RD_I;
                                end
                            OP_MOUSE:
                                if (count_reg != '0)
                                begin
                                    frame_reg <= 1'b0;
                                    i_reg     <= '0;
                                    sat_reg   <= '0;
                                    mpx_reg   <= DIFF_W'({mouse_x, {FRAC_BITS{1'b0}}});
                                    mpy_reg   <= DIFF_W'({mouse_y, {FRAC_BITS{1'b0}}});
                                    q_reg     <= mouse_sign ?
                                                 QS_W'(0) - QS_W'(mforce_reg) :
                                                 QS_W'(mforce_reg);
                                    state_reg <= S_RD_I;
                                end
                            default: ;
                        endcase
                    end
                end

                S_RD_I:
                    state_reg <= S_LD_I;

                S_LD_I:
                begin
                    ei_reg  <= rd_data_reg;
                    mix_reg <= 1'b0;
                    if (rd_data_reg.charge == '0)
                        state_reg <= S_NEXT_I;
                    else if (frame_reg)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_RD_J;
                    end
                    else
                    begin
                        dx_reg    <= mpx_reg - DIFF_W'(rd_data_reg.pos_x);
                        dy_reg    <= mpy_reg - DIFF_W'(rd_data_reg.pos_y);
                        state_reg <= S_FSTART;
                    end
                end

                S_RD_J:
                    state_reg <= S_LD_J;

                S_LD_J:
                begin
                    ej_reg    <= rd_data_reg;
                    state_reg <= S_PAIR;
                end

                S_PAIR:
                begin
                    axis_reg <= 1'b0;
                    if (collide)
                    begin
                        mix_reg   <= 1'b1;
                        state_reg <= S_MIXMUL;
                    end
                    else
                    begin
                        mix_reg   <= 1'b0;
                        dx_reg    <= DIFF_W'(ej_reg.pos_x) - DIFF_W'(ei_reg.pos_x);
                        dy_reg    <= DIFF_W'(ej_reg.pos_y) - DIFF_W'(ei_reg.pos_y);
                        q_reg     <= ei_reg.charge[CHG_W-1] ?
                                     QS_W'(ej_reg.charge) :
                                     QS_W'(0) - QS_W'(ej_reg.charge);
                        state_reg <= S_FSTART;
                    end
                end

                // S = dx^2 + dy^2
                S_FSTART:
                begin
                    acc_reg    <= '0;
                    mcand_reg  <= DEN_W'(ax);
                    mplier_reg <= R25_W'(ax);
                    cnt_reg    <= STEP_W'(MAG_W);
                    axis_reg   <= 1'b0;
                    state_reg  <= S_MULX;
                end

                S_MULX:
                begin
                    acc_reg <= acc_next;
                    if (step_last)
                    begin
                        mcand_reg  <= DEN_W'(ay);
                        mplier_reg <= R25_W'(ay);
                        cnt_reg    <= STEP_W'(MAG_W);
                        state_reg  <= S_MULY;
                    end
                    else
                    begin
                        mcand_reg  <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                        cnt_reg    <= cnt_reg - STEP_W'(1);
                    end
                end

                S_MULY:
                begin
                    if (step_last)
                    begin
                        s_reg     <= acc_next[SQ_W-1:0];
                        rad_reg   <= acc_next[SQ_W-1:0];
                        root_reg  <= '0;
                        srem_reg  <= '0;
                        cnt_reg   <= STEP_W'(ROOT_W);
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        acc_reg    <= acc_next;
                        mcand_reg  <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                        cnt_reg    <= cnt_reg - STEP_W'(1);
                    end
                end

                S_SQRT:
                begin
                    srem_reg <= root_bit ? (srem_shift - srem_trial) : srem_shift;
                    root_reg <= {root_reg[ROOT_W-2:0], root_bit};
                    rad_reg  <= rad_reg << 2;
                    cnt_reg  <= cnt_reg - STEP_W'(1);
                    if (step_last)
                        state_reg <= S_R25;
                end

                // den = S * (25 * R)
                S_R25:
                begin
                    acc_reg    <= '0;
                    mcand_reg  <= DEN_W'(s_reg);
                    mplier_reg <= r25;
                    cnt_reg    <= STEP_W'(R25_W);
                    state_reg  <= S_MULD;
                end

                S_MULD:
                begin
                    acc_reg    <= acc_next;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg - STEP_W'(1);
                    if (step_last)
                    begin
                        den_reg   <= acc_next;
                        state_reg <= S_DSET;
                    end
                end

                // quotient = (|q| * |dn|) << 3F / den
                S_DSET:
                begin
                    nshift_reg <= {prod_q, {(NUM_W-PROD_W){1'b0}}};
                    rem_reg    <= '0;
                    cnt_reg    <= STEP_W'(NUM_W);
                    state_reg  <= S_DIV;
                end

                S_DIV:
                begin
                    rem_reg    <= rem_next;
                    quo_reg    <= {quo_reg[NUM_W-2:0], quo_bit};
                    nshift_reg <= nshift_reg << 1;
                    cnt_reg    <= cnt_reg - STEP_W'(1);
                    if (step_last)
                        state_reg <= S_DEND;
                end

                S_DEND:
                begin
                    if (mix_reg)
                    begin
                        if (axis_reg)
                        begin
                            ei_reg.vel_y <= v_mix;
                            ej_reg.vel_y <= v_mix;
                            state_reg    <= S_WR_I;
                        end
                        else
                        begin
                            ei_reg.vel_x <= v_mix;
                            ej_reg.vel_x <= v_mix;
                            axis_reg     <= 1'b1;
                            state_reg    <= S_MIXMUL;
                        end
                    end
                    else
                    begin
                        if (v_over || v_under)
                            sat_reg[i_reg] <= 1'b1;
                        if (axis_reg)
                        begin
                            ei_reg.vel_y <= v_force;
                            state_reg    <= S_WR_I;
                        end
                        else
                        begin
                            ei_reg.vel_x <= v_force;
                            axis_reg     <= 1'b1;
                            state_reg    <= S_DSET;
                        end
                    end
                end

                // collision: |q|-weighted mean of both velocities
                S_MIXMUL:
                begin
                    pa_reg    <= MIX_W'($signed({1'b0, qi_mag})) *
                                 MIX_W'(axis_reg ? ei_reg.vel_y : ei_reg.vel_x);
                    pb_reg    <= MIX_W'($signed({1'b0, qj_mag})) *
                                 MIX_W'(axis_reg ? ej_reg.vel_y : ej_reg.vel_x);
                    state_reg <= S_MIXSUM;
                end

                S_MIXSUM:
                begin
                    neg_reg    <= mix_sum[MIX_W];
                    nshift_reg <= {mix_mag, {(NUM_W-MIX_W){1'b0}}};
                    den_reg    <= DEN_W'(q_sum);
                    rem_reg    <= '0;
                    cnt_reg    <= STEP_W'(MIX_W);
                    state_reg  <= S_DIV;
                end

                S_WR_I:
                begin
                    if (!frame_reg)
                        state_reg <= S_NEXT_I;
                    else if (mix_reg)
                        state_reg <= S_WR_J;
                    else if (j_last)
                        state_reg <= S_NEXT_I;
                    else
                    begin
                        j_reg     <= j_reg + IDX_W'(1);
                        state_reg <= S_RD_J;
                    end
                end

                S_WR_J:
                begin
                    if (j_last)
                        state_reg <= S_NEXT_I;
                    else
                    begin
                        j_reg     <= j_reg + IDX_W'(1);
                        state_reg <= S_RD_J;
                    end
                end

                S_NEXT_I:
                begin
                    if (i_last)
                    begin
                        i_reg     <= '0;
                        state_reg <= frame_reg ? S_POS_RD : S_EMIT_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= S_RD_I;
                    end
                end

                S_POS_RD:
                    state_reg <= S_POS_LD;

                S_POS_LD:
                begin
                    ei_reg    <= rd_data_reg;
                    state_reg <= S_POS_WR;
                end

                S_POS_WR:
                begin
                    if (i_last)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= S_POS_RD;
                    end
                end

                // read the next entry only once the output register frees up
                S_EMIT_RD:
                    if (!out_valid_reg || !out_stall)
                        state_reg <= S_EMIT_LD;

                S_EMIT_LD:
                begin
                    out_valid_reg <= 1'b1;
                    index_reg     <= 6'(i_reg);
                    out_reg       <= rd_data_reg;
                    sat_out_reg   <= sat_reg[i_reg];
                    last_reg      <= i_last;
                    if (i_last)
                        state_reg <= S_IDLE;
                    else
                    begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= S_EMIT_RD;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign index      = index_reg;
    assign charge_out = out_reg.charge;
    assign pos_x_out  = out_reg.pos_x;
    assign pos_y_out  = out_reg.pos_y;
    assign vel_x_out  = out_reg.vel_x;
    assign vel_y_out  = out_reg.vel_y;
    assign saturated  = sat_out_reg;
    assign last       = last_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CHARGES))
        else $error("entry count above store depth");

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg != S_IDLE)) |-> (CNT_W'(mem_waddr) < count_reg))
        else $error("sequencer write outside filled entries");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_LD) |-> !out_valid_reg)
        else $error("output register overwritten before transaction");

    a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_LD && !i_last) |=> (index_reg + 6'd1 == 6'(i_reg)))
        else $error("emitted index out of sequence");

endmodule
